// ===== rtl/imh_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed max-heap block.
// ---------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY     = 1024;
  localparam int HANDLE_COUNT = 1024;
  localparam int SLOT_W       = $clog2(CAPACITY + 1);
  localparam int HANDLE_W     = 10;
  localparam int HIDX_W       = $clog2(HANDLE_COUNT);
  localparam int VALUE_W      = 32;
  localparam int ENTRY_W      = VALUE_W + HANDLE_W;
  localparam logic [VALUE_W-1:0] EMPTY_RESET = 32'd228;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_ERASE = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  value;
    logic [HANDLE_W-1:0] handle;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic               heap_empty;
    logic [10:0]        entry_count;
    logic [1:0]         status;
  } out_beat_t;

  // Entry as stored: order key is the value with flipped sign, then handle.
  typedef struct packed {
    logic [VALUE_W-1:0]  key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POS_RD, S_DECIDE, S_TAIL_RD, S_UP_RD, S_UP_CMP,
    S_DN_RD, S_DN_CMP, S_TOP_RD, S_DONE
  } state_t;

  // One heap memory access: two read addresses and optional write.
  typedef struct packed {
    logic [SLOT_W-1:0] rd_a;
    logic [SLOT_W-1:0] rd_b;
    logic              we;
    logic [SLOT_W-1:0] wa;
    entry_t            wd;
  } heap_req_t;

  typedef struct packed {
    logic [HIDX_W-1:0] addr;
    logic              we;
    logic [SLOT_W-1:0] wd;
  } pos_req_t;

  function automatic logic gt(entry_t a, entry_t b);
    return {a.key, a.handle} > {b.key, b.handle};
  endfunction

endpackage

// ===== rtl/imh_heap_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imh_heap_ram
// Heap slot storage: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module imh_heap_ram (
  input  logic                clk,
  input  imh_pkg::heap_req_t  req,
  output imh_pkg::entry_t     rd_a,
  output imh_pkg::entry_t     rd_b
);
  import imh_pkg::*;

  entry_t mem [0:CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    rd_a <= mem[req.rd_a];
    rd_b <= mem[req.rd_b];
  end

endmodule

// ===== rtl/imh_pos_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imh_pos_ram
// Handle to slot map. Cleared by a sweep after reset; zero means absent.
// ---------------------------------------------------------------------------
module imh_pos_ram (
  input  logic                       clk,
  input  imh_pkg::pos_req_t          req,
  output logic [imh_pkg::SLOT_W-1:0] rd
);
  import imh_pkg::*;

  logic [SLOT_W-1:0] mem [0:HANDLE_COUNT-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wd;
    end
    rd <= mem[req.addr];
  end

endmodule

// ===== rtl/indexed_max_heap_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_max_heap_top
// Indexed binary max-heap with push, erase by handle and query.
// ---------------------------------------------------------------------------
// After reset the handle map is cleared one entry a cycle, and busy stays high
// until all HANDLE_COUNT (1024) entries are cleared. An item is taken when
// start is high and busy is low; its single result appears for one cycle with
// out_valid and cannot be held off. A query reads the handle map, decides and
// reads the top slot; a push or an erase sifts the entry between those steps,
// and every level that a sift climbs or descends passes through a read state
// and a compare state. The slot memory has registered reads, and every
// compare-and-swap step waits on its read.
module indexed_max_heap_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  imh_pkg::in_beat_t    in_beat,
  output logic                 out_valid,
  output imh_pkg::out_beat_t   out_beat,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import imh_pkg::*;

  state_t state_r, state_nxt;
  logic [VALUE_W-1:0] empty_r;
  logic [SLOT_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  oth_r, oth_nxt;     // slot whose children are compared
  logic               down_r, down_nxt;   // erase still needs a sift up
  logic               clr_r;
  logic [HIDX_W:0]    clr_cnt_r;
  in_beat_t           item_r;
  logic [1:0]         status_r, status_nxt;
  entry_t             cur_r, cur_nxt;     // entry being sifted
  heap_req_t          hreq;
  pos_req_t           preq;
  entry_t             rd_a, rd_b;
  logic [SLOT_W-1:0]  pos_rd;
  logic               hv_ok;
  logic [SLOT_W-1:0]  left, best;
  entry_t             best_e;

  imh_heap_ram u_heap (.clk(clk), .req(hreq), .rd_a(rd_a), .rd_b(rd_b));
  imh_pos_ram  u_pos  (.clk(clk), .req(preq), .rd(pos_rd));

  assign busy  = clr_r || (state_r != S_IDLE);
  assign hv_ok = 1'b1; // every 10-bit handle is below HANDLE_COUNT
  assign left  = {oth_r[SLOT_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      empty_r   <= EMPTY_RESET;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      down_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      down_r  <= down_nxt;
      if (cfg_we) begin
        empty_r <= cfg_wdata;
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (HIDX_W+1)'(HANDLE_COUNT - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    oth_r    <= oth_nxt;
    status_r <= status_nxt;
    cur_r    <= cur_nxt;
    if (start && !busy) begin
      item_r <= in_beat;
    end
  end

  // Larger child: rd_a holds left, rd_b holds right in S_DN_CMP.
  always_comb begin
    if ((left + 1'b1) <= fill_r && gt(rd_b, rd_a)) begin
      best   = left + 1'b1;
      best_e = rd_b;
    end else begin
      best   = left;
      best_e = rd_a;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (start && !busy) state_nxt = S_POS_RD;
      S_POS_RD:  state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (status_nxt != ST_OK) state_nxt = S_TOP_RD;
        else if (item_r.mode == MODE_PUSH) state_nxt = S_UP_RD;
        else if (item_r.mode == MODE_ERASE) state_nxt = S_TAIL_RD;
        else state_nxt = S_TOP_RD;
      end
      // When the erased entry was the tail itself there is nothing to move.
      S_TAIL_RD: state_nxt = (slot_r > fill_r) ? S_TOP_RD : S_DN_RD;
      S_UP_RD:   state_nxt = (slot_r > SLOT_W'(1)) ? S_UP_CMP : S_TOP_RD;
      S_UP_CMP:  state_nxt = gt(cur_r, rd_a) ? S_UP_RD : S_TOP_RD;
      S_DN_RD:   state_nxt = ({slot_r, 1'b0} <= {1'b0, fill_r}) ? S_DN_CMP :
                             (down_r ? S_UP_RD : S_TOP_RD);
      S_DN_CMP:  state_nxt = gt(best_e, cur_r) ? S_DN_RD :
                             (down_r ? S_UP_RD : S_TOP_RD);
      S_TOP_RD:  state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    hreq       = '0;
    preq       = '0;
    fill_nxt   = fill_r;
    slot_nxt   = slot_r;
    oth_nxt    = oth_r;
    status_nxt = status_r;
    cur_nxt    = cur_r;
    down_nxt   = down_r;
    hreq.rd_a  = '0;
    hreq.rd_b  = '0;
    preq.addr  = item_r.handle[HIDX_W-1:0];
    if (clr_r) begin
      preq.addr = clr_cnt_r[HIDX_W-1:0];
      preq.we   = 1'b1;
      preq.wd   = '0;
    end
    case (state_r)
      S_IDLE: begin
        if (!clr_r) preq.addr = in_beat.handle[HIDX_W-1:0];
        status_nxt = ST_OK;
      end
      S_DECIDE: begin
        if (item_r.mode == MODE_PUSH) begin
          if (!hv_ok) status_nxt = ST_ABSENT;
          else if (pos_rd != '0) status_nxt = ST_PRESENT;
          else if (fill_r >= SLOT_W'(CAPACITY)) status_nxt = ST_FULL;
          else begin
            fill_nxt    = fill_r + 1'b1;
            slot_nxt    = fill_r + 1'b1;
            cur_nxt.key = item_r.value ^ 32'h8000_0000;
            cur_nxt.handle = item_r.handle;
          end
        end else if (item_r.mode == MODE_ERASE) begin
          if (!hv_ok || pos_rd == '0 || pos_rd > fill_r) status_nxt = ST_ABSENT;
          else begin
            slot_nxt   = pos_rd;
            hreq.rd_a  = fill_r;
            preq.we    = 1'b1;
            preq.wd    = '0;
            fill_nxt   = fill_r - 1'b1;
          end
        end
      end
      S_TAIL_RD: begin
        // rd_a holds the tail entry, which moves into the freed slot.
        cur_nxt  = rd_a;
        down_nxt = 1'b1;
        oth_nxt  = slot_r;
      end
      S_UP_RD: begin
        // Place cur at slot, point its handle there, read the parent.
        hreq.we   = 1'b1;
        hreq.wa   = slot_r;
        hreq.wd   = cur_r;
        preq.addr = cur_r.handle[HIDX_W-1:0];
        preq.we   = 1'b1;
        preq.wd   = slot_r;
        hreq.rd_a = slot_r >> 1;
        down_nxt  = 1'b0;
      end
      S_UP_CMP: begin
        if (gt(cur_r, rd_a)) begin
          hreq.we   = 1'b1;
          hreq.wa   = slot_r;
          hreq.wd   = rd_a;
          preq.addr = rd_a.handle[HIDX_W-1:0];
          preq.we   = 1'b1;
          preq.wd   = slot_r;
          slot_nxt  = slot_r >> 1;
        end
      end
      S_DN_RD: begin
        hreq.we   = 1'b1;
        hreq.wa   = slot_r;
        hreq.wd   = cur_r;
        preq.addr = cur_r.handle[HIDX_W-1:0];
        preq.we   = 1'b1;
        preq.wd   = slot_r;
        hreq.rd_a = {slot_r[SLOT_W-2:0], 1'b0};
        hreq.rd_b = {slot_r[SLOT_W-2:0], 1'b1};
        oth_nxt   = slot_r;
      end
      S_DN_CMP: begin
        if (gt(best_e, cur_r)) begin
          hreq.we   = 1'b1;
          hreq.wa   = slot_r;
          hreq.wd   = best_e;
          preq.addr = best_e.handle[HIDX_W-1:0];
          preq.we   = 1'b1;
          preq.wd   = slot_r;
          slot_nxt  = best;
        end
      end
      S_TOP_RD: hreq.rd_a = SLOT_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    out_valid            = (state_r == S_DONE);
    out_beat.heap_empty  = (fill_r == '0);
    out_beat.max_value   = (fill_r == '0) ? empty_r : (rd_a.key ^ 32'h8000_0000);
    out_beat.entry_count = 11'(fill_r);
    out_beat.status      = status_r;
  end

endmodule

// ===== rtl/imh_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imh_checker
// Port-level checks for the indexed max-heap block.
// ---------------------------------------------------------------------------
module imh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input imh_pkg::out_beat_t out_beat
);
  import imh_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy low after accepted beat");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without a beat in flight");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.heap_empty == (out_beat.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results in a row");

endmodule

bind indexed_max_heap_top imh_checker u_imh_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_beat(out_beat)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed max-heap: push, erase, query and odd-mode
// beats are checked against a behavioral heap kept alongside the block.
// ---------------------------------------------------------------------------
module testbench;
  import imh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_ODD   = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  indexed_max_heap_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Behavioral heap: 1-based slots holding {flipped value, handle}.
  logic [41:0] heap_slots [1:CAPACITY];
  int          slot_of [0:HANDLE_COUNT-1];
  int          heap_size;
  logic [31:0] empty_value;

  in_beat_t  pending_beats [$];
  out_beat_t expected_beats [$];
  int        idle_pct = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  bit        stim_done = 1'b0;
  int        live_handles [$];

  function automatic void swap_slots(int a, int b);
    logic [41:0] t;
    t = heap_slots[a];
    heap_slots[a] = heap_slots[b];
    heap_slots[b] = t;
    slot_of[heap_slots[a][9:0]] = a;
    slot_of[heap_slots[b][9:0]] = b;
  endfunction

  function automatic void rise_slot(int s);
    while (s > 1 && heap_slots[s/2] < heap_slots[s]) begin
      swap_slots(s/2, s);
      s = s / 2;
    end
  endfunction

  function automatic void sink_slot(int s);
    int c;
    forever begin
      c = 2 * s;
      if (c > heap_size) break;
      if (c + 1 <= heap_size && heap_slots[c+1] > heap_slots[c]) c = c + 1;
      if (heap_slots[s] < heap_slots[c]) begin
        swap_slots(s, c);
        s = c;
      end else break;
    end
  endfunction

  function automatic out_beat_t apply_heap_op(in_beat_t b);
    out_beat_t r;
    int s;
    r.status = ST_OK;
    if (b.mode == MODE_PUSH) begin
      if (slot_of[b.handle] != 0) r.status = ST_PRESENT;
      else if (heap_size >= CAPACITY) r.status = ST_FULL;
      else begin
        heap_size++;
        heap_slots[heap_size] = {b.value ^ 32'h8000_0000, b.handle};
        slot_of[b.handle] = heap_size;
        rise_slot(heap_size);
      end
    end else if (b.mode == MODE_ERASE) begin
      s = slot_of[b.handle];
      if (s == 0 || s > heap_size) r.status = ST_ABSENT;
      else begin
        swap_slots(s, heap_size);
        heap_size--;
        slot_of[b.handle] = 0;
        if (s <= heap_size) begin
          sink_slot(s);
          rise_slot(s);
        end
      end
    end
    r.heap_empty = (heap_size == 0);
    r.max_value = r.heap_empty ? empty_value : heap_slots[1][41:10] ^ 32'h8000_0000;
    r.entry_count = heap_size[10:0];
    return r;
  endfunction

  function automatic void queue_op(logic [1:0] m, logic [31:0] v, logic [9:0] h);
    in_beat_t b;
    int i;
    b.mode = m;
    b.value = v;
    b.handle = h;
    pending_beats.insert(pending_beats.size(), b);
    // Track live handles roughly so random erases mostly hit.
    if (m == MODE_PUSH) live_handles.insert(live_handles.size(), int'(h));
    else if (m == MODE_ERASE) begin
      for (i = 0; i < live_handles.size(); i++)
        if (live_handles[i] == h) begin
          live_handles.delete(i);
          break;
        end
    end
  endfunction

  // Driver: prediction is made when the beat is accepted.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_beats.insert(expected_beats.size(), apply_heap_op(in_beat));
      void'(pending_beats.pop_front());
    end
    // The head of the queue is always the next beat not yet accepted.
    if (rst_n && pending_beats.size() > 0 && ($urandom_range(99) >= idle_pct)) begin
      start <= 1'b1;
      in_beat <= pending_beats[0];
    end else start <= 1'b0;
  end

  // Monitor.
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_beat);
        error_count++;
      end else begin
        e = expected_beats.pop_front();
        if (out_beat !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_beat);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_beats.size() == 0 && !start);
    wait (expected_beats.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_empty_value(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    empty_value = v;
  endtask

  task automatic random_phase(int n, int pct);
    int i, k;
    logic [1:0] m;
    idle_pct = pct;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) m = MODE_PUSH;
      else if (k < 85) m = MODE_ERASE;
      else m = $urandom_range(1) ? MODE_QUERY : MODE_ODD;
      if (m == MODE_ERASE && live_handles.size() > 0 && $urandom_range(9) > 1)
        queue_op(m, $urandom, live_handles[$urandom_range(live_handles.size()-1)]);
      else if ($urandom_range(3) == 0)
        queue_op(m, $urandom, $urandom_range(1023));
      else
        queue_op(m, $urandom_range(3) == 0 ? $urandom_range(7) : $urandom,
                 $urandom_range(63));
    end
    drain();
  endtask

  initial begin
    int i;
    empty_value = EMPTY_RESET;
    heap_size = 0;
    for (i = 0; i < HANDLE_COUNT; i++) slot_of[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queries, extremes, duplicates, absent erases, ties.
    queue_op(MODE_QUERY, 0, 0);
    queue_op(MODE_ERASE, 0, 5);
    queue_op(MODE_PUSH, 32'h7fff_ffff, 10'd1023);
    queue_op(MODE_PUSH, 32'h8000_0000, 10'd0);
    queue_op(MODE_PUSH, 32'h7fff_ffff, 10'd0);
    queue_op(MODE_PUSH, 32'h7fff_ffff, 10'd512);
    queue_op(MODE_PUSH, 32'hffff_ffff, 10'd341);
    queue_op(MODE_PUSH, 32'h0, 10'd682);
    queue_op(MODE_ODD, 32'h1234, 10'd3);
    queue_op(MODE_ERASE, 0, 10'd1023);
    queue_op(MODE_ERASE, 0, 10'd1023);
    queue_op(MODE_ERASE, 0, 10'd0);
    queue_op(MODE_ERASE, 0, 10'd512);
    queue_op(MODE_ERASE, 0, 10'd682);
    queue_op(MODE_ERASE, 0, 10'd341);
    queue_op(MODE_QUERY, 0, 0);
    drain();

    write_empty_value(32'h8000_0000);
    random_phase(180, 0);
    write_empty_value(32'h7fff_ffff);
    random_phase(180, 52);
    write_empty_value($urandom);
    random_phase(180, 22);
    write_empty_value(32'h0);
    random_phase(120, 0);

    // Duplicate push, erase and re-push of the same handle, then more traffic.
    idle_pct = 0;
    queue_op(MODE_PUSH, 32'h5, 10'd7);
    queue_op(MODE_ERASE, 0, 10'd7);
    queue_op(MODE_PUSH, 32'h7fff_ffff, 10'd7);
    queue_op(MODE_PUSH, 32'h1, 10'd8);
    random_phase(60, 52);

    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
